// File: design/stl_pkg.sv
// Shared types, character constants and token helpers for the script token lexer.
// Self-contained; imported by script_token_lexer_unit.
package stl_pkg;

   // Token kinds
   localparam logic [5:0] KIND_LBRACE   = 6'd0;
   localparam logic [5:0] KIND_RBRACE   = 6'd1;
   localparam logic [5:0] KIND_LBRACKET = 6'd2;
   localparam logic [5:0] KIND_RBRACKET = 6'd3;
   localparam logic [5:0] KIND_LPAREN   = 6'd4;
   localparam logic [5:0] KIND_RPAREN   = 6'd5;
   localparam logic [5:0] KIND_PLUS     = 6'd6;
   localparam logic [5:0] KIND_MINUS    = 6'd7;
   localparam logic [5:0] KIND_STAR     = 6'd8;
   localparam logic [5:0] KIND_DIV      = 6'd9;
   localparam logic [5:0] KIND_SEMI     = 6'd10;
   localparam logic [5:0] KIND_COMMA    = 6'd11;
   localparam logic [5:0] KIND_DOT      = 6'd12;
   localparam logic [5:0] KIND_COLON    = 6'd13;
   localparam logic [5:0] KIND_ASSIGN   = 6'd14;
   localparam logic [5:0] KIND_EQ       = 6'd15;
   localparam logic [5:0] KIND_GT       = 6'd16;
   localparam logic [5:0] KIND_GE       = 6'd17;
   localparam logic [5:0] KIND_LT       = 6'd18;
   localparam logic [5:0] KIND_LE       = 6'd19;
   localparam logic [5:0] KIND_AMP      = 6'd20;
   localparam logic [5:0] KIND_BANG     = 6'd21;
   localparam logic [5:0] KIND_NE       = 6'd22;
   localparam logic [5:0] KIND_NUMBER   = 6'd23;
   localparam logic [5:0] KIND_IDENT    = 6'd24;
   localparam logic [5:0] KIND_STRING   = 6'd25;
   localparam logic [5:0] KIND_IF       = 6'd26;
   localparam logic [5:0] KIND_WHILE    = 6'd27;
   localparam logic [5:0] KIND_ELSE     = 6'd28;
   localparam logic [5:0] KIND_FOR      = 6'd29;
   localparam logic [5:0] KIND_RETURN   = 6'd30;
   localparam logic [5:0] KIND_FUNCTION = 6'd31;
   localparam logic [5:0] KIND_UNKNOWN  = 6'd32;
   localparam logic [5:0] KIND_END      = 6'd33;
   localparam logic [5:0] KIND_UNTERM   = 6'd34;

   // Characters with special meaning
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOLLAR = 8'h24;

   // Keywords: the window holds the first KW_CHARS bytes of an identifier
   localparam int KW_CHARS = 8;
   localparam int KW_COUNT = 6;
   localparam logic [15:0] KW_CHARS_LEN = 16'(KW_CHARS);
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'h0000_0000_0000_6966,   // if
      64'h0000_0077_6869_6C65,   // while
      64'h0000_0000_656C_7365,   // else
      64'h0000_0000_0066_6F72,   // for
      64'h0000_7265_7475_726E,   // return
      64'h6675_6E63_7469_6F6E    // function
   };
   localparam logic [15:0] KW_LEN [KW_COUNT] = '{16'd2, 16'd5, 16'd4, 16'd3, 16'd6, 16'd8};
   localparam logic [5:0] KW_KIND [KW_COUNT] = '{
      KIND_IF, KIND_WHILE, KIND_ELSE, KIND_FOR, KIND_RETURN, KIND_FUNCTION
   };

   localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] U16_MAX   = 16'hFFFF;

   localparam int RSP_DATA_WIDTH = 80;
   localparam int QUEUE_DEPTH    = 6;

   typedef enum logic [10:0] {
      MODE_IDLE    = 11'b000_0000_0001,
      MODE_SLASH   = 11'b000_0000_0010,
      MODE_COMMENT = 11'b000_0000_0100,
      MODE_EQ      = 11'b000_0000_1000,
      MODE_GT      = 11'b000_0001_0000,
      MODE_LT      = 11'b000_0010_0000,
      MODE_BANG    = 11'b000_0100_0000,
      MODE_NUMBER  = 11'b000_1000_0000,
      MODE_IDENT   = 11'b001_0000_0000,
      MODE_DSTR    = 11'b010_0000_0000,
      MODE_SSTR    = 11'b100_0000_0000
   } mode_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [30:0] value;
   } tok_type;

   typedef struct packed {
      logic    valid;
      tok_type tok;
   } cand_type;

   typedef struct packed {
      tok_type tok;
      logic    last;
   } ent_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] kind;
   } punct_type;

   function automatic logic [15:0] sat_inc16(logic [15:0] x);
      return (x == U16_MAX) ? x : x + 16'd1;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_id_first(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == CH_UNDER) || (c == CH_DOLLAR);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // acc * 10 + digit, saturating
   function automatic logic [30:0] mac10(logic [30:0] acc, logic [7:0] c);
      logic [34:0] sum;
      sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + 35'(c - CH_0);
      return (sum > 35'(VALUE_MAX)) ? VALUE_MAX : sum[30:0];
   endfunction

   function automatic punct_type punct_lookup(logic [7:0] c);
      punct_type r;
      r.hit = 1'b1;
      case (c)
         "{": r.kind = KIND_LBRACE;
         "}": r.kind = KIND_RBRACE;
         "[": r.kind = KIND_LBRACKET;
         "]": r.kind = KIND_RBRACKET;
         "(": r.kind = KIND_LPAREN;
         ")": r.kind = KIND_RPAREN;
         "+": r.kind = KIND_PLUS;
         "-": r.kind = KIND_MINUS;
         "*": r.kind = KIND_STAR;
         ";": r.kind = KIND_SEMI;
         ",": r.kind = KIND_COMMA;
         ".": r.kind = KIND_DOT;
         ":": r.kind = KIND_COLON;
         CH_AMP: r.kind = KIND_AMP;
         default: begin
            r.hit  = 1'b0;
            r.kind = KIND_UNKNOWN;
         end
      endcase
      return r;
   endfunction

   function automatic logic [5:0] ident_kind(logic [15:0] len, logic [63:0] win);
      logic [5:0] k;
      k = KIND_IDENT;
      if (len <= KW_CHARS_LEN) begin
         for (int i = 0; i < KW_COUNT; i++) begin
            if ((len == KW_LEN[i]) && (win == KW_TEXT[i])) k = KW_KIND[i];
         end
      end
      return k;
   endfunction

   function automatic logic [5:0] pair_kind(mode_type mode);
      logic [5:0] k;
      case (mode)
         MODE_EQ: k = KIND_EQ;
         MODE_GT: k = KIND_GE;
         MODE_LT: k = KIND_LE;
         default: k = KIND_NE;
      endcase
      return k;
   endfunction

   // Token that the open scan mode yields if the text stops here; line left zero
   function automatic cand_type close_token(mode_type mode, logic [15:0] start,
                                            logic [15:0] len, logic [30:0] acc,
                                            logic [63:0] win);
      cand_type r;
      r = '0;
      r.valid = 1'b1;
      r.tok.start  = start;
      r.tok.length = len;
      unique case (mode)
         MODE_SLASH: begin
            r.tok.kind = KIND_DIV;
            r.tok.length = 16'd1;
         end
         MODE_EQ: begin
            r.tok.kind = KIND_ASSIGN;
            r.tok.length = 16'd1;
         end
         MODE_GT: begin
            r.tok.kind = KIND_GT;
            r.tok.length = 16'd1;
         end
         MODE_LT: begin
            r.tok.kind = KIND_LT;
            r.tok.length = 16'd1;
         end
         MODE_BANG: begin
            r.tok.kind = KIND_BANG;
            r.tok.length = 16'd1;
         end
         MODE_NUMBER: begin
            r.tok.kind  = KIND_NUMBER;
            r.tok.value = acc;
         end
         MODE_IDENT: r.tok.kind = ident_kind(len, win);
         MODE_DSTR, MODE_SSTR: r.tok.kind = KIND_UNTERM;
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// File: design/script_token_lexer_unit.sv
// Script token lexer: takes source text a byte per transaction and emits tokens by span.
// Depends on stl_pkg for token types, character constants and lookup functions.
// A token enters the registered result queue on the byte transaction that closes it.
// Throughput: one byte per cycle while the result queue has room for three tokens;
// results drain at one per cycle while rsp_tready is high; a byte can close up to three tokens.
// Reset: synchronous, clears the scan state, position (0), line count (1) and the queue.
module script_token_lexer_unit
   import stl_pkg::*;
#(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] text_byte
   input  logic                      req_tlast,   // final_byte
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [15:0] token_start, [31:16] token_length,
                                                  // [47:32] line_number, [78:48] number_value,
                                                  // [79] zero
   output logic [5:0]                rsp_tuser,   // [5:0] token_kind
   output logic                      rsp_tlast    // run_last
);

   localparam logic [2:0] READY_LIMIT = 3'(QUEUE_DEPTH - 3);
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   // Scan state
   mode_type                  mode_ff,  mode_in;
   logic [POSITION_WIDTH-1:0] pos_ff,   pos_in;
   logic [15:0]               line_ff,  line_in;
   logic [15:0]               start_ff, start_in;
   logic [15:0]               len_ff,   len_in;
   logic [30:0]               acc_ff,   acc_in;
   logic [63:0]               win_ff,   win_in;
   logic                      esc_ff,   esc_in;

   // Result queue, head at entry zero
   ent_type [QUEUE_DEPTH-1:0] q_ff, q_in;
   logic [2:0]                cnt_ff, cnt_in;

   logic req_take, rsp_take;

   // Intermediate values of the per-byte pass
   mode_type    mode1, mode2;
   logic [15:0] len1, len2, line1, line2, start2;
   logic [30:0] acc1, acc2;
   logic [63:0] win1, win2;
   logic        esc1, esc2;
   logic        again;
   cand_type    close_a, close_c, tok_a, tok_b, tok_c, tok_e;
   cand_type    cand [3];
   ent_type     new_q [3];
   logic [1:0]  new_cnt;
   punct_type   punct;
   logic [POSITION_WIDTH-1:0] end_pos;
   logic [POSITION_WIDTH+15:0] pos_ext, end_ext;
   logic [15:0] pos16, end16;
   logic [7:0]  c;

   assign req_tready = (cnt_ff <= READY_LIMIT);
   assign req_take   = req_tvalid & req_tready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_take   = rsp_tvalid & rsp_tready;

   assign rsp_tdata = {1'b0, q_ff[0].tok.value, q_ff[0].tok.line,
                       q_ff[0].tok.length, q_ff[0].tok.start};
   assign rsp_tuser = q_ff[0].tok.kind;
   assign rsp_tlast = q_ff[0].last;

   // Byte positions; token_start shows the low 16 bits, saturating at the top
   assign end_pos = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POSITION_WIDTH'(1);
   assign pos_ext = {16'd0, pos_ff};
   assign end_ext = {16'd0, end_pos};
   assign pos16   = pos_ext[15:0];
   assign end16   = end_ext[15:0];

   assign c     = req_tdata;
   assign punct = punct_lookup(c);

   // Lexer pass: continue the open token, rescan the byte from idle, then close on final byte
   always_comb begin
      mode1 = mode_ff;
      len1  = len_ff;
      acc1  = acc_ff;
      win1  = win_ff;
      esc1  = esc_ff;
      line1 = line_ff;
      again = 1'b0;
      tok_a = '0;
      close_a = close_token(mode_ff, start_ff, len_ff, acc_ff, win_ff);

      unique case (mode_ff)
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               mode1 = MODE_COMMENT;
            end else begin
               tok_a = close_a;
               again = 1'b1;
            end
         end
         MODE_COMMENT: begin
            // an LF ends the comment and counts a line
            if (c == CH_LF) begin
               line1 = sat_inc16(line_ff);
               mode1 = MODE_IDLE;
            end
         end
         MODE_EQ, MODE_GT, MODE_LT, MODE_BANG: begin
            if (c == CH_EQUAL) begin
               tok_a.valid      = 1'b1;
               tok_a.tok.kind   = pair_kind(mode_ff);
               tok_a.tok.start  = start_ff;
               tok_a.tok.length = 16'd2;
               mode1 = MODE_IDLE;
            end else begin
               tok_a = close_a;
               again = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               acc1 = mac10(acc_ff, c);
               len1 = sat_inc16(len_ff);
            end else begin
               tok_a = close_a;
               again = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_id_first(c) || is_digit(c)) begin
               // keep only the first bytes for keyword matching
               if (len_ff < KW_CHARS_LEN) win1 = {win_ff[55:0], c};
               len1 = sat_inc16(len_ff);
            end else begin
               tok_a = close_a;
               again = 1'b1;
            end
         end
         MODE_DSTR, MODE_SSTR: begin
            len1 = sat_inc16(len_ff);
            if (esc_ff) begin
               esc1 = 1'b0;
            end else if (c == CH_BSLASH) begin
               esc1 = 1'b1;
            end else if (c == ((mode_ff == MODE_DSTR) ? CH_DQUOTE : CH_SQUOTE)) begin
               tok_a.valid      = 1'b1;
               tok_a.tok.kind   = KIND_STRING;
               tok_a.tok.start  = start_ff;
               tok_a.tok.length = len1;
               mode1 = MODE_IDLE;
            end
         end
         default: begin
            again = 1'b1;
         end
      endcase
      if (again) mode1 = MODE_IDLE;
      tok_a.tok.line = line_ff;

      // rescan the byte from idle
      mode2  = mode1;
      len2   = len1;
      acc2   = acc1;
      win2   = win1;
      esc2   = esc1;
      line2  = line1;
      start2 = start_ff;
      tok_b  = '0;
      tok_b.tok.start  = pos16;
      tok_b.tok.length = 16'd1;
      tok_b.tok.line   = line_ff;
      if (again) begin
         if (is_space(c)) begin
            if (c == CH_LF) line2 = sat_inc16(line1);
         end else if (c == CH_SLASH) begin
            mode2 = MODE_SLASH;
         end else if (punct.hit) begin
            tok_b.valid    = 1'b1;
            tok_b.tok.kind = punct.kind;
         end else if (c == CH_EQUAL) begin
            mode2 = MODE_EQ;
         end else if (c == CH_GT) begin
            mode2 = MODE_GT;
         end else if (c == CH_LT) begin
            mode2 = MODE_LT;
         end else if (c == CH_BANG) begin
            mode2 = MODE_BANG;
         end else if (is_digit(c)) begin
            mode2 = MODE_NUMBER;
            acc2  = 31'(c - CH_0);
         end else if (is_id_first(c)) begin
            mode2 = MODE_IDENT;
            win2  = {56'd0, c};
         end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            mode2 = (c == CH_DQUOTE) ? MODE_DSTR : MODE_SSTR;
            esc2  = 1'b0;
         end else begin
            tok_b.valid    = 1'b1;
            tok_b.tok.kind = KIND_UNKNOWN;
         end
         // any token opened here starts at this byte
         if (mode2 != MODE_IDLE) begin
            start2 = pos16;
            len2   = 16'd1;
         end
      end

      // final byte: close what is open, then the end token on the updated line
      close_c = close_token(mode2, start2, len2, acc2, win2);
      tok_c = req_tlast ? close_c : '0;
      tok_c.tok.line = line_ff;
      tok_e = '0;
      tok_e.valid     = req_tlast;
      tok_e.tok.kind  = KIND_END;
      tok_e.tok.start = end16;
      tok_e.tok.line  = line2;
   end

   // Pack the candidates in order; the rescan token and the final close never coexist
   always_comb begin
      logic [1:0] idx;
      cand[0] = tok_a;
      cand[1] = tok_b.valid ? tok_b : tok_c;
      cand[2] = tok_e;
      idx = 2'd0;
      for (int k = 0; k < 3; k++) begin
         new_q[k] = '0;
      end
      for (int k = 0; k < 3; k++) begin
         if (cand[k].valid) begin
            new_q[idx].tok  = cand[k].tok;
            new_q[idx].last = (k == 0) ? !cand[1].valid && !cand[2].valid :
                              (k == 1) ? !cand[2].valid : 1'b1;
            idx = idx + 2'd1;
         end
      end
      new_cnt = idx;
   end

   // Queue update: shift on a drained transaction, append the new tokens behind
   always_comb begin
      logic [2:0]                base;
      logic [2:0]                off;
      ent_type [QUEUE_DEPTH-1:0] shifted;
      base    = cnt_ff - {2'b00, rsp_take};
      shifted = rsp_take ? {ent_type'('0), q_ff[QUEUE_DEPTH-1:1]} : q_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         off = 3'(i) - base;
         if (3'(i) < base) begin
            q_in[i] = shifted[i];
         end else if (req_take && (off < {1'b0, new_cnt})) begin
            q_in[i] = new_q[off[1:0]];
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      cnt_in = base + (req_take ? {1'b0, new_cnt} : 3'd0);
   end

   // Next scan state; the final byte returns everything to its reset value
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      start_in = start_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      win_in   = win_ff;
      esc_in   = esc_ff;
      if (req_take) begin
         if (req_tlast) begin
            mode_in  = MODE_IDLE;
            pos_in   = '0;
            line_in  = 16'd1;
            start_in = 16'd0;
            len_in   = 16'd0;
            acc_in   = 31'd0;
            win_in   = 64'd0;
            esc_in   = 1'b0;
         end else begin
            mode_in  = mode2;
            pos_in   = end_pos;
            line_in  = line2;
            start_in = start2;
            len_in   = len2;
            acc_in   = acc2;
            win_in   = win2;
            esc_in   = esc2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         line_ff  <= 16'd1;
         start_ff <= 16'd0;
         len_ff   <= 16'd0;
         acc_ff   <= 31'd0;
         win_ff   <= 64'd0;
         esc_ff   <= 1'b0;
         cnt_ff   <= 3'd0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         acc_ff   <= acc_in;
         win_ff   <= win_in;
         esc_ff   <= esc_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Queue payload, no reset needed
   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

// File: tb/script_token_lexer_unit_tb.sv
// Testbench for script_token_lexer_unit: streams script text a byte per transaction and
// checks every emitted token against a lexer model kept inside the bench.
// Depends on stl_pkg for the token kinds, scan modes, character codes and bus widths.
module script_token_lexer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stl_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [15:0] POS_MAX = 16'hFFFF;

   // Keyword spellings, right-aligned the way the window fills up
   localparam logic [63:0] WORD_IF = "if";
   localparam logic [63:0] WORD_WHILE = "while";
   localparam logic [63:0] WORD_ELSE = "else";
   localparam logic [63:0] WORD_FOR = "for";
   localparam logic [63:0] WORD_RETURN = "return";
   localparam logic [63:0] WORD_FUNCTION = "function";

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [30:0] value;
      logic        last;
   } token_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;   // [7:0] text_byte
   logic                      req_tlast = 1'b0; // final_byte
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;        // [15:0] start, [31:16] length,
                                                // [47:32] line, [78:48] value, [79] zero
   logic [5:0]                rsp_tuser;        // [5:0] token_kind
   logic                      rsp_tlast;        // run_last

   // Tokens still owed by the block, oldest first, and the ones one byte produces
   token_type  expected_tokens[$];
   token_type  byte_tokens[$];
   // Text under construction, sent as one run with the final flag on its last byte
   logic [7:0] text_q[$];

   // Lexer model state
   mode_type    lex_mode;
   logic [15:0] lex_pos;
   logic [15:0] lex_line;
   logic [15:0] lex_start;
   logic [15:0] lex_len;
   logic [30:0] lex_acc;
   logic [63:0] lex_window;
   logic        lex_escape;

   // Sender and receiver pacing
   int          burst_left = 0;
   bit          steady = 1'b0;
   int          hold_left = 0;
   int          pattern_age = 0;
   logic [15:0] ready_pattern = '1;

   int error_count = 0;
   int cycle_count = 0;

   string SYMBOLS = "{}[]()+-*/;,.:&=<>!";
   string PAIR_HEADS = "=<>!";
   string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$0123456789";

   script_token_lexer_unit #(
      .POSITION_WIDTH(16)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Lexer model
   // ---------------------------------------------------------------------------

   function automatic logic is_num(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_word_head(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == "_") || (c == "$");
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [15:0] grow16(logic [15:0] n);
      return (n == 16'hFFFF) ? n : n + 16'd1;
   endfunction

   function automatic void lex_reset();
      lex_mode = MODE_IDLE;
      lex_pos = '0;
      lex_line = 16'd1;
      lex_start = '0;
      lex_len = '0;
      lex_acc = '0;
      lex_window = '0;
      lex_escape = 1'b0;
   endfunction

   function automatic void bump_line();
      if (lex_line != 16'hFFFF) lex_line = lex_line + 16'd1;
   endfunction

   // Every token carries the line count at the moment it is emitted
   function automatic void emit_token(logic [5:0] kind, logic [15:0] start,
                                      logic [15:0] len, logic [30:0] value);
      token_type t;
      t.kind = kind;
      t.start = start;
      t.length = len;
      t.line = lex_line;
      t.value = value;
      t.last = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   // Whole-word match only; anything past eight characters stays an identifier
   function automatic logic [5:0] word_kind();
      logic [5:0] k;
      k = KIND_IDENT;
      case (lex_len)
         16'd2: if (lex_window == WORD_IF) k = KIND_IF;
         16'd3: if (lex_window == WORD_FOR) k = KIND_FOR;
         16'd4: if (lex_window == WORD_ELSE) k = KIND_ELSE;
         16'd5: if (lex_window == WORD_WHILE) k = KIND_WHILE;
         16'd6: if (lex_window == WORD_RETURN) k = KIND_RETURN;
         16'd8: if (lex_window == WORD_FUNCTION) k = KIND_FUNCTION;
         default: ;
      endcase
      return k;
   endfunction

   // Kind of a one-character comparison operator; its two-character form is one up
   function automatic logic [5:0] lone_kind(mode_type m);
      case (m)
         MODE_EQ: return KIND_ASSIGN;
         MODE_GT: return KIND_GT;
         MODE_LT: return KIND_LT;
         default: return KIND_BANG;
      endcase
   endfunction

   function automatic logic [5:0] punct_code(logic [7:0] c);
      case (c)
         "{": return KIND_LBRACE;
         "}": return KIND_RBRACE;
         "[": return KIND_LBRACKET;
         "]": return KIND_RBRACKET;
         "(": return KIND_LPAREN;
         ")": return KIND_RPAREN;
         "+": return KIND_PLUS;
         "-": return KIND_MINUS;
         "*": return KIND_STAR;
         ";": return KIND_SEMI;
         ",": return KIND_COMMA;
         ".": return KIND_DOT;
         ":": return KIND_COLON;
         "&": return KIND_AMP;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   // Close whatever token is open as if the text stopped here
   function automatic void close_token();
      case (lex_mode)
         MODE_SLASH: emit_token(KIND_DIV, lex_start, 16'd1, '0);
         MODE_EQ, MODE_GT, MODE_LT, MODE_BANG:
            emit_token(lone_kind(lex_mode), lex_start, 16'd1, '0);
         MODE_NUMBER: emit_token(KIND_NUMBER, lex_start, lex_len, lex_acc);
         MODE_IDENT: emit_token(word_kind(), lex_start, lex_len, '0);
         MODE_DSTR, MODE_SSTR: emit_token(KIND_UNTERM, lex_start, lex_len, '0);
         default: ;
      endcase
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void open_token(mode_type m);
      lex_mode = m;
      lex_start = lex_pos;
      lex_len = 16'd1;
   endfunction

   // A byte seen between tokens
   function automatic void scan_fresh(logic [7:0] c);
      if (is_blank(c)) begin
         if (c == CH_LF) bump_line();
      end else if (c == CH_SLASH) begin
         open_token(MODE_SLASH);
      end else if (c == CH_EQUAL) begin
         open_token(MODE_EQ);
      end else if (c == CH_GT) begin
         open_token(MODE_GT);
      end else if (c == CH_LT) begin
         open_token(MODE_LT);
      end else if (c == CH_BANG) begin
         open_token(MODE_BANG);
      end else if (is_num(c)) begin
         open_token(MODE_NUMBER);
         lex_acc = 31'(c - CH_0);
      end else if (is_word_head(c)) begin
         open_token(MODE_IDENT);
         lex_window = {56'd0, c};
      end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
         open_token((c == CH_DQUOTE) ? MODE_DSTR : MODE_SSTR);
         lex_escape = 1'b0;
      end else begin
         emit_token(punct_code(c), lex_pos, 16'd1, '0);
      end
   endfunction

   // Advance the model by one accepted byte and queue the tokens it closes
   function automatic void model_byte(logic [7:0] c, logic fin);
      logic        rescan;
      logic [35:0] grown;
      int          n;
      token_type   t;
      rescan = 1'b0;
      byte_tokens.delete();
      case (lex_mode)
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               lex_mode = MODE_COMMENT;
            end else begin
               close_token();
               rescan = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (c == CH_LF) begin
               bump_line();
               lex_mode = MODE_IDLE;
            end
         end
         MODE_EQ, MODE_GT, MODE_LT, MODE_BANG: begin
            if (c == CH_EQUAL) begin
               emit_token(lone_kind(lex_mode) + 6'd1, lex_start, 16'd2, '0);
               lex_mode = MODE_IDLE;
            end else begin
               close_token();
               rescan = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_num(c)) begin
               grown = 36'(lex_acc) * 36'd10 + 36'(c - CH_0);
               lex_acc = (grown > 36'(VALUE_MAX)) ? VALUE_MAX : grown[30:0];
               lex_len = grow16(lex_len);
            end else begin
               close_token();
               rescan = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_word_head(c) || is_num(c)) begin
               if (lex_len < 16'd8) lex_window = {lex_window[55:0], c};
               lex_len = grow16(lex_len);
            end else begin
               close_token();
               rescan = 1'b1;
            end
         end
         MODE_DSTR, MODE_SSTR: begin
            // A backslash hides the next byte, closing quote included
            lex_len = grow16(lex_len);
            if (lex_escape) begin
               lex_escape = 1'b0;
            end else if (c == CH_BSLASH) begin
               lex_escape = 1'b1;
            end else if (c == ((lex_mode == MODE_DSTR) ? CH_DQUOTE : CH_SQUOTE)) begin
               emit_token(KIND_STRING, lex_start, lex_len, '0);
               lex_mode = MODE_IDLE;
            end
         end
         default: rescan = 1'b1;
      endcase
      if (rescan) scan_fresh(c);

      if (lex_pos != POS_MAX) lex_pos = lex_pos + 16'd1;

      // Final byte: flush the open token, report the end, start over
      if (fin) begin
         close_token();
         emit_token(KIND_END, lex_pos, 16'd0, '0);
         lex_reset();
      end

      n = byte_tokens.size();
      for (int i = 0; i < n; i++) begin
         t = byte_tokens[i];
         t.last = (i == n - 1);
         expected_tokens.push_back(t);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------------

   task automatic send_byte(logic [7:0] c, logic fin);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (steady) gap = 0;
         else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
         else gap = $urandom_range(0, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= fin;
      // Hold the byte until the block takes it
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_byte(c, fin);
   endtask

   // Send the built-up text as one run, final flag on its last byte
   task automatic send_text();
      int n;
      n = text_q.size();
      for (int i = 0; i < n; i++) send_byte(text_q[i], i == n - 1);
      text_q.delete();
   endtask

   // Drop valid and hold off until every owed token has arrived
   task automatic wait_for_tokens();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   // ---------------------------------------------------------------------------
   // Receiver: rotate a ready pattern, swap it now and then; honor long hold-offs
   // ---------------------------------------------------------------------------

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ready_pattern[0];
      end
      if (pattern_age == 0) begin
         pattern_age = $urandom_range(16, 96);
         case ($urandom_range(0, 3))
            0: ready_pattern <= '1;
            1: ready_pattern <= 16'($urandom);
            2: ready_pattern <= 16'($urandom | $urandom);
            default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
         endcase
      end else begin
         pattern_age--;
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   // ---------------------------------------------------------------------------
   // Checking: each accepted token against the oldest expectation
   // ---------------------------------------------------------------------------

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : token_checker
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                     $time, rsp_tuser, rsp_tdata[15:0]);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", 32'(want.kind), 32'(rsp_tuser));
            check_field("token_start", 32'(want.start), 32'(rsp_tdata[15:0]));
            check_field("token_length", 32'(want.length), 32'(rsp_tdata[31:16]));
            check_field("line_number", 32'(want.line), 32'(rsp_tdata[47:32]));
            check_field("number_value", 32'(want.value), 32'(rsp_tdata[78:48]));
            check_field("run_last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // Watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d tokens owed", $time,
                  expected_tokens.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Punctuation, every comparison in both widths, division, odd bytes
   task automatic test_single_tokens();
      add_str("{}[]()+-*;,.:&");
      add_str("==!=<=>==<>!/x");
      text_q.push_back(8'h00);
      text_q.push_back(8'h80);
      text_q.push_back(8'hFF);
      send_text();
      wait_for_tokens();
   endtask

   // Every keyword, then a number past saturation
   task automatic test_words();
      add_str("if while else for return function 2147483648");
      send_text();
      wait_for_tokens();
   endtask

   // Both quote kinds, an escaped quote, the other quote inside, newline inside, unterminated
   task automatic test_strings();
      add_str("\"a\\\"b\" 'x\"' \"n\nl\" 'op");
      send_text();
      add_str("\"\\");
      send_text();
      wait_for_tokens();
   endtask

   // Comments, whitespace bytes, line counting, tokens left open at the final byte
   task automatic test_comments_and_lines();
      add_str("a//x\nb/c\r\n\t");
      text_q.push_back(8'h0B);
      send_text();
      add_str("x/");
      send_text();
      add_str("//");
      send_text();
      add_str("7");
      send_text();
      add_str(">");
      send_text();
      wait_for_tokens();
   endtask

   // Starve the result side for a long stretch while bytes keep coming
   task automatic test_backpressure();
      steady = 1'b1;
      hold_left = 100;
      repeat (4) add_str("(;");
      add_str("x<=");
      send_text();
      steady = 1'b0;
      wait_for_tokens();
   endtask

   function automatic void add_piece();
      int quote;
      case ($urandom_range(0, 11))
         0, 1: text_q.push_back(SYMBOLS[$urandom_range(0, SYMBOLS.len() - 1)]);
         2: begin
            text_q.push_back(PAIR_HEADS[$urandom_range(0, 3)]);
            text_q.push_back(CH_EQUAL);
         end
         3: repeat ($urandom_range(1, 12)) text_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
         4, 5: begin
            text_q.push_back(WORD_CHARS[$urandom_range(0, 53)]);
            repeat ($urandom_range(0, 11))
               text_q.push_back(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
         end
         6: begin
            case ($urandom_range(0, 5))
               0: add_str("if");
               1: add_str("while");
               2: add_str("else");
               3: add_str("for");
               4: add_str("return");
               default: add_str("function");
            endcase
         end
         7: begin
            quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            text_q.push_back(8'(quote));
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 5))
                  0: text_q.push_back(CH_BSLASH);
                  1: text_q.push_back((quote == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
                  2: text_q.push_back(CH_LF);
                  default: text_q.push_back(8'($urandom_range(32, 126)));
               endcase
            end
            // Leave some strings open on purpose
            if ($urandom_range(0, 6) != 0) text_q.push_back(8'(quote));
         end
         8: begin
            add_str("//");
            repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 3) != 0) text_q.push_back(CH_LF);
         end
         9: text_q.push_back(8'($urandom_range(9, 13)));
         10: text_q.push_back(8'($urandom_range(0, 255)));
         default: text_q.push_back(CH_LF);
      endcase
   endfunction

   // Mostly well-formed token sequences, some glued, with noise and loose ends
   task automatic test_random_texts();
      int sent;
      sent = 0;
      while (sent < 12) begin
         repeat ($urandom_range(3, 6)) begin
            add_piece();
            if ($urandom_range(0, 1)) text_q.push_back(CH_SPACE);
         end
         sent += text_q.size();
         send_text();
         if ($urandom_range(0, 3) == 0) wait_for_tokens();
      end
      wait_for_tokens();
   endtask

   initial begin
      lex_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_tokens();
      test_words();
      test_strings();
      test_comments_and_lines();
      test_backpressure();
      test_random_texts();

      wait_for_tokens();
      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/stl_pkg.sv
design/script_token_lexer_unit.sv
tb/script_token_lexer_unit_tb.sv
